/* hdl/tqt_pkg.sv */
// ============================================================================
// tqt_pkg: shared types and constants of the temperature qualifier
// Register indexes, default widths and the reset values of registers and state.
// ============================================================================
package tqt_pkg;

  // Default widths
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF  = 8;

  // Width of the byte-wide configuration fields
  localparam int unsigned BYTE_BITS = 8;

  // Number of configuration registers and width of their index
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

  // Reset values of the configuration registers
  localparam int RST_HEATER_SP   = 400;
  localparam int RST_TANK_FAN_SP = 424;
  localparam int RST_LAMP_FAN_SP = 640;
  localparam int RST_DEADBAND    = 3;
  localparam int RST_VALID_LOW   = 160;
  localparam int RST_VALID_HIGH  = 1360;
  localparam int RST_STEP_WINDOW = 16;
  localparam int RST_ERROR_LIMIT = 5;

  // Error count after reset, clamped to the counter range where needed
  localparam int ERRORS_AT_RESET = 5;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEATER_SP   = 3'd0,
    REG_TANK_FAN_SP = 3'd1,
    REG_LAMP_FAN_SP = 3'd2,
    REG_DEADBAND    = 3'd3,
    REG_VALID_LOW   = 3'd4,
    REG_VALID_HIGH  = 3'd5,
    REG_STEP_WINDOW = 3'd6,
    REG_ERROR_LIMIT = 3'd7
  } cfg_reg_e;

endpackage

/* hdl/tqt_qual.sv */
// ============================================================================
// tqt_qual: sensor qualification for one temperature channel
// Holds the stored value and the error counter, rejects out-of-limit samples
// and large jumps; at the error limit it takes a jump or, out of limits, zero.
// ============================================================================
module tqt_qual
  import tqt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] valid_low_i,
  input  logic signed [SAMPLE_BITS-1:0] valid_high_i,
  input  logic        [BYTE_BITS-1:0]   step_window_i,
  input  logic        [BYTE_BITS-1:0]   error_limit_i,
  output logic signed [SAMPLE_BITS-1:0] value_o
);

  localparam int unsigned EXT_W = SAMPLE_BITS + 2;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_RST =
      (ERRORS_AT_RESET > (2 ** COUNT_BITS) - 1) ? CNT_MAX : COUNT_BITS'(ERRORS_AT_RESET);

  logic signed [SAMPLE_BITS-1:0] stored_q, stored_d;
  logic        [COUNT_BITS-1:0]  errors_q, errors_d;

  logic                          out_limits;
  logic                          in_window;
  logic signed [EXT_W-1:0]       stored_ext, sample_ext, win_ext;
  logic        [COUNT_BITS-1:0]  errors_inc;
  logic                          limit_hit;

  always_comb begin
    out_limits = (sample_i <= valid_low_i) || (sample_i >= valid_high_i);

    stored_ext = EXT_W'(stored_q);
    sample_ext = EXT_W'(sample_i);
    win_ext    = signed'({{(EXT_W - BYTE_BITS){1'b0}}, step_window_i});
    in_window  = (stored_ext + win_ext > sample_ext) && (stored_ext - win_ext < sample_ext);

    // The counter saturates instead of wrapping
    errors_inc = (errors_q == CNT_MAX) ? CNT_MAX : errors_q + 1'b1;
    limit_hit  = BYTE_BITS'(errors_inc) >= error_limit_i;

    stored_d = stored_q;
    errors_d = errors_inc;
    if (out_limits) begin
      if (limit_hit) begin
        stored_d = '0;
      end
    end else if (in_window) begin
      stored_d = sample_i;
      errors_d = '0;
    end else if (limit_hit) begin
      stored_d = sample_i;
      errors_d = '0;
    end
  end

  assign value_o = stored_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      errors_q <= CNT_RST;
    end else if (en_i) begin
      stored_q <= stored_d;
      errors_q <= errors_d;
    end
  end

endmodule

/* hdl/temperature_qualify_thermostat_top.sv */
// ============================================================================
// temperature_qualify_thermostat_top: sensor qualifier and relay thermostat
// Qualifies tank and lamp samples and drives heater and fans with a deadband.
// ============================================================================
// Flow: an accepted item waits in the input register and moves on to the result
// register when that is empty or being taken. Throughput: one item per cycle
// while results are taken; the input register and the result register form a
// two-stage pipeline, and the state updates as an item leaves the first.
// Reset: configuration returns to its defaults, stored values to zero, error
// counts to five, all relays off, and both pipeline stages empty.
module temperature_qualify_thermostat_top
  import tqt_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
  localparam int unsigned IN_W  = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * SAMPLE_BITS + 3 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tank_sample, lamp_sample, water_change (lowest bits first), zero pad
  input  logic [IN_W-1:0]        s_axis_tdata,
  // Result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tank_temp, lamp_temp, heater_on, tank_fan_on, lamp_fan_on, zero pad
  output logic [OUT_W-1:0]       m_axis_tdata,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [REG_IDX_W-1:0]   cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i
);

  localparam int unsigned SW    = SAMPLE_BITS;
  localparam int unsigned EXT_W = SW + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers. Write them only while the block is idle; the block
  // itself does not enforce this. The port is always ready.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]        heater_sp_q, tank_fan_sp_q, lamp_fan_sp_q;
  logic signed [SW-1:0]        valid_low_q, valid_high_q;
  logic        [BYTE_BITS-1:0] deadband_q, step_window_q, error_limit_q;
  cfg_reg_e                    cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_sp_q   <= SW'(RST_HEATER_SP);
      tank_fan_sp_q <= SW'(RST_TANK_FAN_SP);
      lamp_fan_sp_q <= SW'(RST_LAMP_FAN_SP);
      deadband_q    <= BYTE_BITS'(RST_DEADBAND);
      valid_low_q   <= SW'(RST_VALID_LOW);
      valid_high_q  <= SW'(RST_VALID_HIGH);
      step_window_q <= BYTE_BITS'(RST_STEP_WINDOW);
      error_limit_q <= BYTE_BITS'(RST_ERROR_LIMIT);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg)
        REG_HEATER_SP:   heater_sp_q   <= cfg_data_i;
        REG_TANK_FAN_SP: tank_fan_sp_q <= cfg_data_i;
        REG_LAMP_FAN_SP: lamp_fan_sp_q <= cfg_data_i;
        REG_DEADBAND:    deadband_q    <= cfg_data_i[BYTE_BITS-1:0];
        REG_VALID_LOW:   valid_low_q   <= cfg_data_i;
        REG_VALID_HIGH:  valid_high_q  <= cfg_data_i;
        REG_STEP_WINDOW: step_window_q <= cfg_data_i[BYTE_BITS-1:0];
        REG_ERROR_LIMIT: error_limit_q <= cfg_data_i[BYTE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage one is the input register; stage two is the
  // result register. An item moves from one to two whenever stage two is
  // empty or its item is being taken, and that move commits the state.
  // ---------------------------------------------------------------------------
  logic          in_vld_q, in_vld_d;
  logic          out_vld_q, out_vld_d;
  logic          s_accept, advance;
  logic [SW-1:0] tank_in_q, lamp_in_q;
  logic          wc_in_q;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || !out_vld_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tank_in_q <= s_axis_tdata[SW-1:0];
      lamp_in_q <= s_axis_tdata[2*SW-1:SW];
      wc_in_q   <= s_axis_tdata[2*SW];
    end
  end

  // ---------------------------------------------------------------------------
  // Channel qualification. Each instance returns the updated stored value.
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] tank_val, lamp_val;

  tqt_qual #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_qual_tank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .sample_i      (tank_in_q),
    .valid_low_i   (valid_low_q),
    .valid_high_i  (valid_high_q),
    .step_window_i (step_window_q),
    .error_limit_i (error_limit_q),
    .value_o       (tank_val)
  );

  tqt_qual #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_qual_lamp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .sample_i      (lamp_in_q),
    .valid_low_i   (valid_low_q),
    .valid_high_i  (valid_high_q),
    .step_window_i (step_window_q),
    .error_limit_i (error_limit_q),
    .value_o       (lamp_val)
  );

  // ---------------------------------------------------------------------------
  // Thermostat. Each relay switches at its setpoint and holds its state in
  // the deadband just below it. The sums are widened by two bits so that the
  // deadband never overflows. During a water change the heater holds.
  // ---------------------------------------------------------------------------
  logic                    heater_q, heater_d;
  logic                    tank_fan_q, tank_fan_d;
  logic                    lamp_fan_q, lamp_fan_d;
  logic signed [EXT_W-1:0] tank_ext, lamp_ext, db_ext;
  logic signed [EXT_W-1:0] heater_sp_ext, tank_fan_sp_ext, lamp_fan_sp_ext;

  always_comb begin
    tank_ext        = EXT_W'(tank_val);
    lamp_ext        = EXT_W'(lamp_val);
    db_ext          = signed'({{(EXT_W - BYTE_BITS){1'b0}}, deadband_q});
    heater_sp_ext   = EXT_W'(heater_sp_q);
    tank_fan_sp_ext = EXT_W'(tank_fan_sp_q);
    lamp_fan_sp_ext = EXT_W'(lamp_fan_sp_q);

    heater_d = heater_q;
    if (!wc_in_q) begin
      if (tank_ext >= heater_sp_ext) begin
        heater_d = 1'b0;
      end else if (tank_ext + db_ext < heater_sp_ext) begin
        heater_d = 1'b1;
      end
    end

    // Reaching the tank fan setpoint also forces the heater off outside a water change
    tank_fan_d = tank_fan_q;
    if (tank_ext >= tank_fan_sp_ext) begin
      tank_fan_d = 1'b1;
      if (!wc_in_q) begin
        heater_d = 1'b0;
      end
    end else if (tank_ext + db_ext < tank_fan_sp_ext) begin
      tank_fan_d = 1'b0;
    end

    lamp_fan_d = lamp_fan_q;
    if (lamp_ext >= lamp_fan_sp_ext) begin
      lamp_fan_d = 1'b1;
    end else if (lamp_ext + db_ext < lamp_fan_sp_ext) begin
      lamp_fan_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q   <= 1'b0;
      tank_fan_q <= 1'b0;
      lamp_fan_q <= 1'b0;
    end else if (advance) begin
      heater_q   <= heater_d;
      tank_fan_q <= tank_fan_d;
      lamp_fan_q <= lamp_fan_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It holds the item until the downstream side takes it.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_W'({lamp_fan_d, tank_fan_d, heater_d, lamp_val, tank_val});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
